### sv/set_assoc_lru_cache_tags_unit_defines.svh
`ifndef SET_ASSOC_LRU_CACHE_TAGS_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_UNIT_DEFINES_SVH

// implication in the same cycle and in the next cycle
`ifndef NO_ASSERTIONS
`define SACL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SACL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

	localparam int TOTAL_LINES = 16;
	localparam int NUM_WAYS    = 2;
	localparam int BLOCK_BYTES = 8;
	localparam int ADDR_BITS   = 32;

	localparam int SET_COUNT = (TOTAL_LINES / NUM_WAYS) > 0 ? (TOTAL_LINES / NUM_WAYS) : 1;
	localparam int OFS_W     = $clog2(BLOCK_BYTES);
	localparam int SET_W     = SET_COUNT > 1 ? $clog2(SET_COUNT) : 1;
	localparam int TAG_W     = ADDR_BITS - OFS_W - SET_W;
	localparam int WAY_W     = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
	localparam int RANK_W    = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
	localparam int CNT_W     = 32;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic [NUM_WAYS-1:0]             vld;
		logic [NUM_WAYS-1:0][TAG_W-1:0]  tag;
		logic [NUM_WAYS-1:0][RANK_W-1:0] rank;
	} row_t;

	typedef struct packed {
		logic             hit;
		logic             replaced;
		logic [WAY_W-1:0] way;
		row_t             row;
	} upd_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
	endfunction

endpackage

`default_nettype wire

### sv/set_assoc_lru_cache_tags_unit.sv
// channel | handshake                 | word
// --------+---------------------------+-----------------------------------------------
// input   | in_valid / in_stall       | op, address
// output  | out_valid / out_stall     | hit, replaced, way_used, set_used, four counts
//
// a word reads its set row from the tag ram at the accepting edge and is updated and written
// back at the edge where it leaves the update stage, where its result is registered; words
// follow one per cycle while out_stall is low, a ram bypass covers a same-set write and read.
// reset clears the per-set valid flags and the counters at once: no clearing pass.
// a clear word resets flags and counters in its update cycle.
// out_stall holds the update stage, which raises in_stall while a word waits there.
`default_nettype none
`include "set_assoc_lru_cache_tags_unit_defines.svh"

module set_assoc_lru_cache_tags_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [31:0] address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             hit,
	output logic             replaced,
	output logic             way_used,
	output logic [2:0]       set_used,
	output logic [31:0]      hit_count,
	output logic [31:0]      miss_count,
	output logic [31:0]      access_count,
	output logic [31:0]      replacement_count
);

	logic                          accept;
	logic                          advance;
	logic                          fire;
	logic [sacl_pkg::SET_W-1:0]    set_in;
	logic                          vld_s1;
	logic                          op_s1;
	logic [sacl_pkg::SET_W-1:0]    set_s1;
	logic [sacl_pkg::TAG_W-1:0]    tag_s1;
	sacl_pkg::row_t                rd_row_s1;
	sacl_pkg::row_t                row_cur;
	sacl_pkg::upd_t                upd;
	logic                          wr_en;
	logic [sacl_pkg::SET_COUNT-1:0] row_vld_q;
	logic                          out_vld_q;
	logic                          hit_q;
	logic                          replaced_q;
	logic                          way_q;
	logic [2:0]                    set_q;
	logic [sacl_pkg::CNT_W-1:0]    hits_q;
	logic [sacl_pkg::CNT_W-1:0]    misses_q;
	logic [sacl_pkg::CNT_W-1:0]    accesses_q;
	logic [sacl_pkg::CNT_W-1:0]    evictions_q;

	assign set_in   = address[sacl_pkg::OFS_W +: sacl_pkg::SET_W];
	assign advance  = !out_vld_q || !out_stall;
	assign in_stall = vld_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign fire     = vld_s1 && advance;
	assign wr_en    = fire && (op_s1 == sacl_pkg::OP_ACCESS);
	assign row_cur  = row_vld_q[set_s1] ? rd_row_s1 : '0;

	sacl_tag_ram u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_set (set_s1),
		.wr_row (upd.row),
		.rd_en  (accept),
		.rd_set (set_in),
		.rd_row (rd_row_s1)
	);

	sacl_lru_update u_upd (
		.row (row_cur),
		.tag (tag_s1),
		.upd (upd)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op;
			set_s1 <= set_in;
			tag_s1 <= address[sacl_pkg::ADDR_BITS-1 -: sacl_pkg::TAG_W];
		end
		if (fire) begin
			if (op_s1 == sacl_pkg::OP_CLEAR) begin
				hit_q      <= 1'b0;
				replaced_q <= 1'b0;
				way_q      <= 1'b0;
				set_q      <= '0;
			end else begin
				hit_q      <= upd.hit;
				replaced_q <= upd.replaced;
				way_q      <= 1'(upd.way);
				set_q      <= 3'(set_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_vld_q   <= 1'b0;
			row_vld_q   <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			accesses_q  <= '0;
			evictions_q <= '0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !advance);
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			if (fire) begin
				if (op_s1 == sacl_pkg::OP_CLEAR) begin
					row_vld_q   <= '0;
					hits_q      <= '0;
					misses_q    <= '0;
					accesses_q  <= '0;
					evictions_q <= '0;
				end else begin
					row_vld_q[set_s1] <= 1'b1;
					accesses_q        <= sacl_pkg::sat_inc(accesses_q);
					if (upd.hit) begin
						hits_q <= sacl_pkg::sat_inc(hits_q);
					end else begin
						misses_q <= sacl_pkg::sat_inc(misses_q);
					end
					if (upd.replaced) begin
						evictions_q <= sacl_pkg::sat_inc(evictions_q);
					end
				end
			end
		end
	end

	assign out_valid         = out_vld_q;
	assign hit               = hit_q;
	assign replaced          = replaced_q;
	assign way_used          = way_q;
	assign set_used          = set_q;
	assign hit_count         = hits_q;
	assign miss_count        = misses_q;
	assign access_count      = accesses_q;
	assign replacement_count = evictions_q;

	`SACL_ASSERT_NEXT(a_clear_flags, clk, arst_n, fire && (op_s1 == sacl_pkg::OP_CLEAR), row_vld_q == '0 && accesses_q == '0, "clear left valid rows or counts")
	`SACL_ASSERT_NEXT(a_access_counted, clk, arst_n, fire && (op_s1 == sacl_pkg::OP_ACCESS), out_vld_q && (accesses_q != '0) && row_vld_q[$past(set_s1)], "access not recorded")
	`SACL_ASSERT_NOW(a_hits_bounded, clk, arst_n, out_vld_q, (hits_q <= accesses_q) && (evictions_q <= misses_q), "counts inconsistent")
	`SACL_ASSERT_NOW(a_hit_no_evict, clk, arst_n, out_vld_q && hit_q, !replaced_q, "hit flagged as replacement")

endmodule

`default_nettype wire

### sv/sacl_tag_ram.sv
`default_nettype none

module sacl_tag_ram (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [sacl_pkg::SET_W-1:0] wr_set,
	input  wire sacl_pkg::row_t             wr_row,
	input  wire logic                       rd_en,
	input  wire logic [sacl_pkg::SET_W-1:0] rd_set,
	output sacl_pkg::row_t                  rd_row
);

	sacl_pkg::row_t mem [sacl_pkg::SET_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
	end

	// bypass when the row being read is written at the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_set == rd_set)) begin
				rd_row <= wr_row;
			end else begin
				rd_row <= mem[rd_set];
			end
		end
	end

endmodule

`default_nettype wire

### sv/sacl_lru_update.sv
`default_nettype none

module sacl_lru_update (
	input  wire sacl_pkg::row_t             row,
	input  wire logic [sacl_pkg::TAG_W-1:0] tag,
	output sacl_pkg::upd_t                  upd
);

	logic                          hit_found;
	logic                          inv_found;
	logic [sacl_pkg::WAY_W-1:0]    hit_way;
	logic [sacl_pkg::WAY_W-1:0]    inv_way;
	logic [sacl_pkg::WAY_W-1:0]    lru_way;
	logic [sacl_pkg::WAY_W-1:0]    way;
	logic                          was_valid;
	logic [sacl_pkg::RANK_W-1:0]   old_rank;
	sacl_pkg::row_t                nrow;

	always_comb begin
		hit_found = 1'b0;
		inv_found = 1'b0;
		hit_way   = '0;
		inv_way   = '0;
		lru_way   = '0;
		for (int i = 0; i < sacl_pkg::NUM_WAYS; i++) begin
			if (!hit_found && row.vld[i] && (row.tag[i] == tag)) begin
				hit_found = 1'b1;
				hit_way   = sacl_pkg::WAY_W'(i);
			end
			if (!inv_found && !row.vld[i]) begin
				inv_found = 1'b1;
				inv_way   = sacl_pkg::WAY_W'(i);
			end
		end
		// oldest way, lowest number on a tie
		for (int i = 1; i < sacl_pkg::NUM_WAYS; i++) begin
			if (row.rank[i] > row.rank[lru_way]) begin
				lru_way = sacl_pkg::WAY_W'(i);
			end
		end
		way       = hit_found ? hit_way : (inv_found ? inv_way : lru_way);
		was_valid = hit_found || !inv_found;
		old_rank  = row.rank[way];
		nrow      = row;
		for (int i = 0; i < sacl_pkg::NUM_WAYS; i++) begin
			if ((sacl_pkg::WAY_W'(i) != way) && row.vld[i] &&
			    (!was_valid || (row.rank[i] < old_rank))) begin
				nrow.rank[i] = row.rank[i] + sacl_pkg::RANK_W'(1);
			end
		end
		nrow.rank[way] = '0;
		nrow.vld[way]  = 1'b1;
		nrow.tag[way]  = tag;
		upd.hit        = hit_found;
		upd.replaced   = !hit_found && !inv_found;
		upd.way        = way;
		upd.row        = nrow;
	end

endmodule

`default_nettype wire

### dv/tb.sv
`default_nettype none

module tb;

	typedef struct {
		logic        op;
		logic [31:0] address;
	} access_t;

	typedef struct {
		logic        hit;
		logic        replaced;
		logic        way;
		logic [2:0]  set_idx;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] accesses;
		logic [31:0] evictions;
	} lookup_t;

	localparam int RANDOM_WORDS   = 1950;
	localparam int CALM_TAIL      = 250;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = sacl_pkg::OP_ACCESS;
	logic [31:0] address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        hit;
	logic        replaced;
	logic        way_used;
	logic [2:0]  set_used;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic [31:0] access_count;
	logic [31:0] replacement_count;

	access_t pending_accesses[$];
	lookup_t due_lookups[$];

	logic [sacl_pkg::TAG_W-1:0] line_tag [sacl_pkg::SET_COUNT][sacl_pkg::NUM_WAYS];
	logic             line_valid [sacl_pkg::SET_COUNT][sacl_pkg::NUM_WAYS];
	int               line_rank [sacl_pkg::SET_COUNT][sacl_pkg::NUM_WAYS];
	logic [31:0]      hits_seen;
	logic [31:0]      misses_seen;
	logic [31:0]      accesses_seen;
	logic [31:0]      evictions_seen;

	int               errors = 0;
	logic             in_fire = 1'b0;
	int               send_gap = 0;
	int               stall_left = 0;
	int               quiet_cycles = 0;
	logic [sacl_pkg::TAG_W-1:0] hot_tags [4];

	set_assoc_lru_cache_tags_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.replaced(replaced),
		.way_used(way_used),
		.set_used(set_used),
		.hit_count(hit_count),
		.miss_count(miss_count),
		.access_count(access_count),
		.replacement_count(replacement_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void flush_cache();
		for (int s = 0; s < sacl_pkg::SET_COUNT; s++) begin
			for (int w = 0; w < sacl_pkg::NUM_WAYS; w++) begin
				line_tag[s][w] = '0;
				line_valid[s][w] = 1'b0;
				line_rank[s][w] = 0;
			end
		end
		hits_seen = '0;
		misses_seen = '0;
		accesses_seen = '0;
		evictions_seen = '0;
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// touched way becomes newest, the more recent valid ways age by one (all valid ways on a fill)
	function automatic void age_set(input int s, input int w, input logic was_valid);
		int old;
		old = line_rank[s][w];
		for (int i = 0; i < sacl_pkg::NUM_WAYS; i++) begin
			if (i != w && line_valid[s][i] && (!was_valid || line_rank[s][i] < old))
				line_rank[s][i] = line_rank[s][i] + 1;
		end
		line_rank[s][w] = 0;
	endfunction

	function automatic lookup_t cache_lookup(input access_t a);
		lookup_t          r;
		logic [31:0]      blk;
		logic [sacl_pkg::TAG_W-1:0] tg;
		int               s;
		int               w;
		logic             found;
		r = '{default: '0};
		if (a.op == sacl_pkg::OP_CLEAR) begin
			flush_cache();
		end else begin
			blk = a.address / sacl_pkg::BLOCK_BYTES;
			s = int'(blk % sacl_pkg::SET_COUNT);
			tg = sacl_pkg::TAG_W'(blk / sacl_pkg::SET_COUNT);
			accesses_seen = bump(accesses_seen);
			found = 1'b0;
			w = 0;
			for (int i = 0; i < sacl_pkg::NUM_WAYS; i++) begin
				if (!found && line_valid[s][i] && line_tag[s][i] == tg) begin
					found = 1'b1;
					w = i;
				end
			end
			if (found) begin
				r.hit = 1'b1;
				hits_seen = bump(hits_seen);
				age_set(s, w, 1'b1);
			end else begin
				misses_seen = bump(misses_seen);
				for (int i = 0; i < sacl_pkg::NUM_WAYS; i++) begin
					if (!found && !line_valid[s][i]) begin
						found = 1'b1;
						w = i;
					end
				end
				if (found) begin
					age_set(s, w, 1'b0);
					line_valid[s][w] = 1'b1;
				end else begin
					w = 0;
					for (int i = 1; i < sacl_pkg::NUM_WAYS; i++) begin
						if (line_rank[s][i] > line_rank[s][w])
							w = i;
					end
					r.replaced = 1'b1;
					evictions_seen = bump(evictions_seen);
					age_set(s, w, 1'b1);
				end
				line_tag[s][w] = tg;
			end
			r.way = w[0];
			r.set_idx = s[2:0];
		end
		r.hits = hits_seen;
		r.misses = misses_seen;
		r.accesses = accesses_seen;
		r.evictions = evictions_seen;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic check_word(input lookup_t want);
		check_field("hit", 32'(hit), 32'(want.hit));
		check_field("replaced", 32'(replaced), 32'(want.replaced));
		check_field("way_used", 32'(way_used), 32'(want.way));
		check_field("set_used", 32'(set_used), 32'(want.set_idx));
		check_field("hit_count", hit_count, want.hits);
		check_field("miss_count", miss_count, want.misses);
		check_field("access_count", access_count, want.accesses);
		check_field("replacement_count", replacement_count, want.evictions);
	endtask

	task automatic queue_access(input logic o, input logic [31:0] a);
		pending_accesses.push_back('{o, a});
	endtask

	// result words are checked before this edge's input word is predicted
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (out_valid && !out_stall) begin
			if (due_lookups.size() == 0)
				report_mismatch("result word with none expected");
			else
				check_word(due_lookups.pop_front());
		end
		if (in_valid && !in_stall)
			due_lookups.push_back(cache_lookup('{op, address}));
	end

	always @(posedge clk) begin
		if (arst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall))
			quiet_cycles = quiet_cycles + 1;
		else
			quiet_cycles = 0;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk) begin
		access_t nxt;
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_accesses.size() > 0) begin
					nxt = pending_accesses.pop_front();
					in_valid <= 1'b1;
					op <= nxt.op;
					address <= nxt.address;
					if (pending_accesses.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 19);
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				if (pending_accesses.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
					stall_left <= $urandom_range(1, 19);
			end
		end
	end

	initial begin
		logic [sacl_pkg::SET_W-1:0] sx;
		logic [sacl_pkg::OFS_W-1:0] ox;
		int               pick;
		flush_cache();

		// fills, hits, lru evictions in sets 0 and 7, clears
		queue_access(sacl_pkg::OP_ACCESS, 32'h0000_0000);
		queue_access(sacl_pkg::OP_ACCESS, 32'h0000_0007);
		queue_access(sacl_pkg::OP_ACCESS, 32'h0000_0040);
		queue_access(sacl_pkg::OP_ACCESS, 32'h0000_0000);
		queue_access(sacl_pkg::OP_ACCESS, 32'h0000_0080);
		queue_access(sacl_pkg::OP_ACCESS, 32'h0000_0040);
		queue_access(sacl_pkg::OP_ACCESS, 32'h0000_0085);
		queue_access(sacl_pkg::OP_ACCESS, 32'hFFFF_FFFF);
		queue_access(sacl_pkg::OP_ACCESS, 32'hFFFF_FFF8);
		queue_access(sacl_pkg::OP_ACCESS, 32'h7FFF_FFF8);
		queue_access(sacl_pkg::OP_ACCESS, 32'h3FFF_FFF8);
		queue_access(sacl_pkg::OP_ACCESS, 32'h0000_0038);
		queue_access(sacl_pkg::OP_CLEAR, 32'hFFFF_FFFF);
		queue_access(sacl_pkg::OP_ACCESS, 32'h0000_0000);
		queue_access(sacl_pkg::OP_ACCESS, 32'h8000_0000);
		queue_access(sacl_pkg::OP_ACCESS, 32'h5555_5555);
		queue_access(sacl_pkg::OP_ACCESS, 32'hAAAA_AAAA);
		queue_access(sacl_pkg::OP_CLEAR, 32'h0000_0000);
		queue_access(sacl_pkg::OP_CLEAR, 32'h1234_5678);
		queue_access(sacl_pkg::OP_ACCESS, 32'h0000_0008);

		// small tag pool per phase so sets see hits and evictions
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 200 == 0) begin
				for (int k = 0; k < 4; k++)
					hot_tags[k] = sacl_pkg::TAG_W'($urandom);
			end
			pick = $urandom_range(0, 99);
			sx = sacl_pkg::SET_W'($urandom_range(0, sacl_pkg::SET_COUNT - 1));
			ox = sacl_pkg::OFS_W'($urandom);
			if (pick < 2)
				queue_access(sacl_pkg::OP_CLEAR, $urandom);
			else if (pick < 17)
				queue_access(sacl_pkg::OP_ACCESS, $urandom);
			else
				queue_access(sacl_pkg::OP_ACCESS, {hot_tags[$urandom_range(0, 3)], sx, ox});
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_accesses.size() > 0 || in_valid || due_lookups.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/sacl_pkg.sv
sv/sacl_tag_ram.sv
sv/sacl_lru_update.sv
sv/set_assoc_lru_cache_tags_unit.sv
dv/tb.sv
